// ===== src/assert_macros.svh =====
// assertion macros used by the splitter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/sws_pkg.sv =====
// types, codes and helpers of the shell word splitter
package sws_pkg;

   // lexer modes
   localparam logic [2:0] MODE_GAP = 3'd0;
   localparam logic [2:0] MODE_UNQ = 3'd1;
   localparam logic [2:0] MODE_SQ  = 3'd2;
   localparam logic [2:0] MODE_DQ  = 3'd3;
   localparam logic [2:0] MODE_ESC = 3'd4;
   localparam logic [2:0] MODE_HEX = 3'd5;
   localparam logic [2:0] MODE_OCT = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_WEND  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // error codes
   localparam logic [2:0] ERR_OPEN_DQ   = 3'd0;
   localparam logic [2:0] ERR_OPEN_SQ   = 3'd1;
   localparam logic [2:0] ERR_RANGE     = 3'd2;
   localparam logic [2:0] ERR_TOO_MANY  = 3'd3;
   localparam logic [2:0] ERR_NO_SLOTS  = 3'd4;

   // configuration
   localparam int          CSR_ADDR_WIDTH  = 3;
   localparam int          CSR_DATA_WIDTH  = 32;
   localparam logic        REG_ARG_SLOTS   = 1'b0;
   localparam logic [7:0]  ARG_SLOTS_RESET = 8'd16;

   // result queue
   localparam int RES_PER_REQ = 3;
   localparam int QUEUE_DEPTH = 4;

   // characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_VT     = 8'h0b;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_V  = 8'h76;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_LOW_O  = 8'h6f;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] word_number;
      logic [2:0] error_code;
      logic       last;
   } result_type;

   function automatic result_type make_result(logic [1:0] kind, logic [7:0] data_byte,
                                              logic [7:0] word_number,
                                              logic [2:0] error_code);
      result_type r;
      r.kind        = kind;
      r.data_byte   = data_byte;
      r.word_number = word_number;
      r.error_code  = error_code;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
             (c == CH_CR) || (c == CH_LF);
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   function automatic logic [3:0] oct_digit(logic [7:0] c);
      logic [3:0] r;
      r = 4'd0;
      if (c >= 8'h30 && c <= 8'h37) r = {1'b1, 3'(c - 8'h30)};
      return r;
   endfunction

endpackage

// ===== src/shell_word_splitter_core.sv =====
// shell word splitter: byte-serial sh-style tokenizer with c escape decoding
//
// Requests carry one command byte (req_ch) or an end-of-string mark
// (req_is_end). Each request yields zero to three results on the rsp_
// channel: decoded data bytes, word ends, a done mark with the word count,
// or an error; rsp_last marks the final result of a request.
// The lexer state is updated in the cycle a request is taken and its results
// are written into a four-entry result queue, which presents them in order on
// the rsp_ channel. One request per cycle is taken while requests give at most
// one result each and the receiver does not stall; a request giving several
// results holds the output until each is taken. A request is taken whenever
// at most one result still waits in the queue, so the queue always has room
// for three more. When the receiver stalls the queue fills and req_stall
// rises; nothing is lost. Reset clears the lexer, empties the queue and sets
// arg_slots to 16. The user must write arg_slots through the apb port at byte
// address 0 only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module shell_word_splitter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_ch,
   input  logic                                 req_is_end,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_kind,
   output logic [7:0]                           rsp_data_byte,
   output logic [7:0]                           rsp_word_number,
   output logic [2:0]                           rsp_error_code,
   output logic                                 rsp_last,
   // configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sws_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [sws_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [sws_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);

   localparam int PTR_WIDTH = $clog2(sws_pkg::QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(sws_pkg::QUEUE_DEPTH + 1);

   logic [7:0]            arg_slots_ff;
   logic [2:0]            lex_mode_ff, lex_mode_in;
   logic                  in_double_ctx_ff, in_double_ctx_in;
   logic [7:0]            escape_value_ff, escape_value_in;
   logic                  gap_pending_ff, gap_pending_in;
   logic [7:0]            word_count_ff, word_count_in;

   sws_pkg::result_type   queue_ff [sws_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  head_ff;
   logic [CNT_WIDTH-1:0]  count_ff;

   sws_pkg::result_type   res      [sws_pkg::RES_PER_REQ];
   logic [1:0]            res_n;
   logic                  proceed;
   logic [4:0]            hex_d;
   logic [3:0]            oct_d;
   logic [11:0]           acc;

   logic                  req_take;
   logic                  rsp_take;
   logic [PTR_WIDTH-1:0]  tail;
   logic                  csr_write;

   // ---------------------------------------------------------------
   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == sws_pkg::REG_ARG_SLOTS) ?
                      {{(sws_pkg::CSR_DATA_WIDTH-8){1'b0}}, arg_slots_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_slots_ff <= sws_pkg::ARG_SLOTS_RESET;
      end else if (csr_write && paddr[2] == sws_pkg::REG_ARG_SLOTS) begin
         arg_slots_ff <= pwdata[7:0];
      end
   end

   // ---------------------------------------------------------------
   // handshake
   assign req_stall = (count_ff > CNT_WIDTH'(1));
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign tail      = head_ff + count_ff[PTR_WIDTH-1:0];

   // ---------------------------------------------------------------
   // lexer step
   always_comb begin
      lex_mode_in      = lex_mode_ff;
      in_double_ctx_in = in_double_ctx_ff;
      escape_value_in  = escape_value_ff;
      gap_pending_in   = gap_pending_ff;
      word_count_in    = word_count_ff;
      res_n            = 2'd0;
      proceed          = 1'b0;
      hex_d            = sws_pkg::hex_digit(req_ch);
      oct_d            = sws_pkg::oct_digit(req_ch);
      acc              = '0;
      for (int i = 0; i < sws_pkg::RES_PER_REQ; i++) begin
         res[i] = sws_pkg::make_result(sws_pkg::KIND_DATA, 8'd0, 8'd0, 3'd0);
      end

      if (gap_pending_ff) begin
         if (req_is_end) begin
            lex_mode_in      = sws_pkg::MODE_GAP;
            in_double_ctx_in = 1'b0;
            escape_value_in  = 8'd0;
            gap_pending_in   = 1'b0;
            word_count_in    = 8'd0;
         end
      end else if (arg_slots_ff == 8'd0) begin
         res[res_n] = sws_pkg::make_result(sws_pkg::KIND_ERROR, 8'd0, 8'd0,
                                           sws_pkg::ERR_NO_SLOTS);
         res_n            = res_n + 2'd1;
         lex_mode_in      = sws_pkg::MODE_GAP;
         in_double_ctx_in = 1'b0;
         escape_value_in  = 8'd0;
         word_count_in    = 8'd0;
         gap_pending_in   = !req_is_end;
      end else if (req_is_end) begin
         // flush a pending escape first
         if (lex_mode_in == sws_pkg::MODE_HEX || lex_mode_in == sws_pkg::MODE_OCT) begin
            res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, escape_value_ff, 8'd0,
                                              3'd0);
            res_n       = res_n + 2'd1;
            lex_mode_in = in_double_ctx_ff ? sws_pkg::MODE_DQ : sws_pkg::MODE_UNQ;
         end else if (lex_mode_in == sws_pkg::MODE_ESC) begin
            res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, 8'd0, 8'd0, 3'd0);
            res_n       = res_n + 2'd1;
            lex_mode_in = in_double_ctx_ff ? sws_pkg::MODE_DQ : sws_pkg::MODE_UNQ;
         end
         if (lex_mode_in == sws_pkg::MODE_SQ) begin
            res[res_n] = sws_pkg::make_result(sws_pkg::KIND_ERROR, 8'd0, 8'd0,
                                              sws_pkg::ERR_OPEN_SQ);
            res_n = res_n + 2'd1;
         end else if (lex_mode_in == sws_pkg::MODE_DQ) begin
            res[res_n] = sws_pkg::make_result(sws_pkg::KIND_ERROR, 8'd0, 8'd0,
                                              sws_pkg::ERR_OPEN_DQ);
            res_n = res_n + 2'd1;
         end else begin
            if (lex_mode_in == sws_pkg::MODE_UNQ) begin
               res[res_n] = sws_pkg::make_result(sws_pkg::KIND_WEND, 8'd0,
                                                 word_count_ff - 8'd1, 3'd0);
               res_n = res_n + 2'd1;
            end
            if (word_count_ff >= arg_slots_ff) begin
               res[res_n] = sws_pkg::make_result(sws_pkg::KIND_ERROR, 8'd0, 8'd0,
                                                 sws_pkg::ERR_TOO_MANY);
            end else begin
               res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DONE, 8'd0,
                                                 word_count_ff, 3'd0);
            end
            res_n = res_n + 2'd1;
         end
         // the string always ends with a clean lexer
         lex_mode_in      = sws_pkg::MODE_GAP;
         in_double_ctx_in = 1'b0;
         escape_value_in  = 8'd0;
         gap_pending_in   = 1'b0;
         word_count_in    = 8'd0;
      end else begin
         // first pass: gap and escape digits, which may hand the byte on
         unique case (lex_mode_in) inside
            sws_pkg::MODE_HEX, sws_pkg::MODE_OCT: begin
               if (lex_mode_in == sws_pkg::MODE_HEX && hex_d[4]) begin
                  acc = {escape_value_ff, 4'd0} + {8'd0, hex_d[3:0]};
               end else if (lex_mode_in == sws_pkg::MODE_OCT && oct_d[3]) begin
                  acc = {1'b0, escape_value_ff, 3'd0} + {9'd0, oct_d[2:0]};
               end
               if ((lex_mode_in == sws_pkg::MODE_HEX && hex_d[4]) ||
                   (lex_mode_in == sws_pkg::MODE_OCT && oct_d[3])) begin
                  if (acc[11:8] != 4'd0) begin
                     res[res_n] = sws_pkg::make_result(sws_pkg::KIND_ERROR, 8'd0, 8'd0,
                                                       sws_pkg::ERR_RANGE);
                     res_n            = res_n + 2'd1;
                     lex_mode_in      = sws_pkg::MODE_GAP;
                     in_double_ctx_in = 1'b0;
                     escape_value_in  = 8'd0;
                     word_count_in    = 8'd0;
                     gap_pending_in   = 1'b1;
                  end else begin
                     escape_value_in = acc[7:0];
                  end
               end else begin
                  res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, escape_value_ff,
                                                    8'd0, 3'd0);
                  res_n       = res_n + 2'd1;
                  lex_mode_in = in_double_ctx_ff ? sws_pkg::MODE_DQ : sws_pkg::MODE_UNQ;
                  proceed     = 1'b1;
               end
            end
            sws_pkg::MODE_UNQ, sws_pkg::MODE_SQ, sws_pkg::MODE_DQ, sws_pkg::MODE_ESC: begin
               proceed = 1'b1;
            end
            default: begin
               // gap, and the unused code
               lex_mode_in = sws_pkg::MODE_GAP;
               if (!sws_pkg::is_space(req_ch)) begin
                  if (word_count_ff >= arg_slots_ff) begin
                     res[res_n] = sws_pkg::make_result(sws_pkg::KIND_ERROR, 8'd0, 8'd0,
                                                       sws_pkg::ERR_TOO_MANY);
                     res_n            = res_n + 2'd1;
                     in_double_ctx_in = 1'b0;
                     escape_value_in  = 8'd0;
                     word_count_in    = 8'd0;
                     gap_pending_in   = 1'b1;
                  end else begin
                     word_count_in = word_count_ff + 8'd1;
                     lex_mode_in   = sws_pkg::MODE_UNQ;
                     proceed       = 1'b1;
                  end
               end
            end
         endcase

         // second pass: the byte in text, quote or escape context
         if (proceed) begin
            unique case (lex_mode_in)
               sws_pkg::MODE_UNQ: begin
                  if (sws_pkg::is_space(req_ch)) begin
                     res[res_n] = sws_pkg::make_result(sws_pkg::KIND_WEND, 8'd0,
                                                       word_count_in - 8'd1, 3'd0);
                     res_n       = res_n + 2'd1;
                     lex_mode_in = sws_pkg::MODE_GAP;
                  end else if (req_ch == sws_pkg::CH_SQUOTE) begin
                     lex_mode_in = sws_pkg::MODE_SQ;
                  end else if (req_ch == sws_pkg::CH_DQUOTE) begin
                     lex_mode_in = sws_pkg::MODE_DQ;
                  end else if (req_ch == sws_pkg::CH_BSLASH) begin
                     in_double_ctx_in = 1'b0;
                     lex_mode_in      = sws_pkg::MODE_ESC;
                  end else begin
                     res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, req_ch, 8'd0,
                                                       3'd0);
                     res_n = res_n + 2'd1;
                  end
               end
               sws_pkg::MODE_SQ: begin
                  if (req_ch == sws_pkg::CH_SQUOTE) begin
                     lex_mode_in = sws_pkg::MODE_UNQ;
                  end else begin
                     res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, req_ch, 8'd0,
                                                       3'd0);
                     res_n = res_n + 2'd1;
                  end
               end
               sws_pkg::MODE_DQ: begin
                  if (req_ch == sws_pkg::CH_DQUOTE) begin
                     lex_mode_in = sws_pkg::MODE_UNQ;
                  end else if (req_ch == sws_pkg::CH_BSLASH) begin
                     in_double_ctx_in = 1'b1;
                     lex_mode_in      = sws_pkg::MODE_ESC;
                  end else begin
                     res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, req_ch, 8'd0,
                                                       3'd0);
                     res_n = res_n + 2'd1;
                  end
               end
               sws_pkg::MODE_ESC: begin
                  lex_mode_in = in_double_ctx_in ? sws_pkg::MODE_DQ : sws_pkg::MODE_UNQ;
                  case (req_ch)
                     sws_pkg::CH_BSLASH, sws_pkg::CH_DQUOTE, sws_pkg::CH_SQUOTE,
                     sws_pkg::CH_SPACE: begin
                        res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, req_ch, 8'd0,
                                                          3'd0);
                        res_n = res_n + 2'd1;
                     end
                     sws_pkg::CH_LOW_F: begin
                        res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, sws_pkg::CH_FF,
                                                          8'd0, 3'd0);
                        res_n = res_n + 2'd1;
                     end
                     sws_pkg::CH_LOW_N: begin
                        res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, sws_pkg::CH_LF,
                                                          8'd0, 3'd0);
                        res_n = res_n + 2'd1;
                     end
                     sws_pkg::CH_LOW_R: begin
                        res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, sws_pkg::CH_CR,
                                                          8'd0, 3'd0);
                        res_n = res_n + 2'd1;
                     end
                     sws_pkg::CH_LOW_T: begin
                        res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, sws_pkg::CH_TAB,
                                                          8'd0, 3'd0);
                        res_n = res_n + 2'd1;
                     end
                     sws_pkg::CH_LOW_V: begin
                        res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, sws_pkg::CH_VT,
                                                          8'd0, 3'd0);
                        res_n = res_n + 2'd1;
                     end
                     sws_pkg::CH_LOW_X: begin
                        escape_value_in = 8'd0;
                        lex_mode_in     = sws_pkg::MODE_HEX;
                     end
                     sws_pkg::CH_LOW_O: begin
                        escape_value_in = 8'd0;
                        lex_mode_in     = sws_pkg::MODE_OCT;
                     end
                     default: begin
                        // unknown escape gives a zero byte
                        res[res_n] = sws_pkg::make_result(sws_pkg::KIND_DATA, 8'd0, 8'd0,
                                                          3'd0);
                        res_n = res_n + 2'd1;
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
      end

      for (int i = 0; i < sws_pkg::RES_PER_REQ; i++) begin
         res[i].last = (res_n == 2'(i + 1));
      end
   end

   // ---------------------------------------------------------------
   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_mode_ff      <= sws_pkg::MODE_GAP;
         in_double_ctx_ff <= 1'b0;
         escape_value_ff  <= 8'd0;
         gap_pending_ff   <= 1'b0;
         word_count_ff    <= 8'd0;
      end else if (req_take) begin
         lex_mode_ff      <= lex_mode_in;
         in_double_ctx_ff <= in_double_ctx_in;
         escape_value_ff  <= escape_value_in;
         gap_pending_ff   <= gap_pending_in;
         word_count_ff    <= word_count_in;
      end
   end

   // ---------------------------------------------------------------
   // result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_ff + PTR_WIDTH'(rsp_take);
         count_ff <= count_ff + (req_take ? CNT_WIDTH'(res_n) : CNT_WIDTH'(0))
                     - CNT_WIDTH'(rsp_take);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < sws_pkg::RES_PER_REQ; i++) begin
            if (2'(i) < res_n) begin
               queue_ff[tail + PTR_WIDTH'(i)] <= res[i];
            end
         end
      end
   end

   assign rsp_kind        = queue_ff[head_ff].kind;
   assign rsp_data_byte   = queue_ff[head_ff].data_byte;
   assign rsp_word_number = queue_ff[head_ff].word_number;
   assign rsp_error_code  = queue_ff[head_ff].error_code;
   assign rsp_last        = queue_ff[head_ff].last;

   // ---------------------------------------------------------------
   // assertions
   `ASSERT_ALWAYS(a_queue_bound, clock, reset,
                  count_ff <= CNT_WIDTH'(sws_pkg::QUEUE_DEPTH), "result queue overflow")
   `ASSERT_IMPLIES(a_error_last, clock, reset,
                   rsp_valid && rsp_kind == sws_pkg::KIND_ERROR, rsp_last,
                   "error result not last of its request")
   `ASSERT_IMPLIES(a_done_last, clock, reset,
                   rsp_valid && rsp_kind == sws_pkg::KIND_DONE, rsp_last,
                   "done result not last of its request")
   `ASSERT_IMPLIES(a_discard_clean, clock, reset, gap_pending_ff,
                   lex_mode_ff == sws_pkg::MODE_GAP && word_count_ff == 8'd0,
                   "lexer not cleared while discarding")

endmodule
